// ----- rtl/srq_pkg.sv -----
// Shared types and codes for the sorted ready queue.
// No dependencies; imported by the core, its checker and the testbench.
package srq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH        = 2'd0,
    OP_PUSH_SORTED = 2'd1,
    OP_POP         = 2'd2,
    OP_PEEK        = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] key;
  } entry_t;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_SHRD   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_INS    = 6'b010000,
    S_SETTLE = 6'b100000
  } state_t;

endpackage

// ----- rtl/sorted_ready_queue_core.sv -----
// Sorted ready queue core: circular entry memory plus a small sequencer.
// Depends on srq_pkg.
//
// Holds up to ENTRY_SLOTS-1 (task id, key) entries in one circular memory with
// a registered read port. Plain push, pop, peek and every rejected request
// pass through the settle state before the next input can be taken.
// A sorted push walks the queue from the head with one key compare per cycle,
// then moves the entries behind the insertion point up by one, one entry per
// cycle through the single memory port pair, then writes the new entry; when no
// queued key is larger the entry is appended at the tail after the walk.
// One result is produced per input item; the result sits in an output
// register, so the next input can be taken in the cycle the result transfers,
// and a stalled result holds off the next input.
module sorted_ready_queue_core
  import srq_pkg::*;
#(
  parameter int ENTRY_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [7:0]  task_id,
  input  logic [15:0] task_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  head_id,
  output logic [15:0] head_key,
  output logic [3:0]  fill
);

  localparam int AW = (ENTRY_SLOTS > 2) ? $clog2(ENTRY_SLOTS) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRY_SLOTS - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    ptr_dec = (p == '0) ? LAST : p - 1'b1;
  endfunction

  entry_t mem [ENTRY_SLOTS];
  entry_t rdata;

  state_t        state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] fill_count, fill_count_next;
  logic [AW-1:0] scan_ptr, scan_ptr_next;
  logic [AW-1:0] dst, dst_next;
  logic [AW-1:0] cnt, cnt_next;
  logic [AW-1:0] ins_ptr, ins_ptr_next;
  entry_t        new_entry, new_entry_next;
  logic          out_valid_next;
  status_t       out_status, out_status_next;
  entry_t        out_entry, out_entry_next;
  logic [AW-1:0] out_fill, out_fill_next;
  logic [AW+3:0] fill_ext;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  logic          in_xfer, out_xfer, out_load, full;

  assign in_ready = !rst && (state == S_IDLE) && (!out_valid || out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = (fill_count == LAST);

  always_comb begin
    state_next      = state;
    head_next       = head;
    tail_next       = tail;
    fill_count_next = fill_count;
    scan_ptr_next   = scan_ptr;
    dst_next        = dst;
    cnt_next        = cnt;
    ins_ptr_next    = ins_ptr;
    new_entry_next  = new_entry;
    out_status_next = out_status;
    out_entry_next  = out_entry;
    out_fill_next   = out_fill;
    out_load        = 1'b0;
    we              = 1'b0;
    waddr           = tail;
    wdata           = new_entry;
    raddr           = head;

    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next      = S_SETTLE;
          out_load        = 1'b1;
          out_status_next = ST_DONE;
          out_entry_next  = '0;
          if (op == OP_PUSH || op == OP_PUSH_SORTED) begin
            if (full) begin
              out_status_next = ST_FULL;
              out_fill_next   = fill_count;
            end else if (op == OP_PUSH || fill_count == '0) begin
              we              = 1'b1;
              waddr           = tail;
              wdata           = '{task_id: task_id, key: task_key};
              tail_next       = ptr_inc(tail);
              fill_count_next = fill_count + 1'b1;
              out_fill_next   = fill_count + 1'b1;
            end else begin
              // walk from the head; rdata already holds the head entry
              out_load       = 1'b0;
              new_entry_next = '{task_id: task_id, key: task_key};
              cnt_next       = '0;
              scan_ptr_next  = head;
              state_next     = S_SCAN;
            end
          end else begin
            if (fill_count == '0) begin
              out_status_next = ST_EMPTY;
              out_fill_next   = fill_count;
            end else begin
              out_entry_next = rdata;
              out_fill_next  = fill_count;
              if (op == OP_POP) begin
                head_next       = ptr_inc(head);
                fill_count_next = fill_count - 1'b1;
                out_fill_next   = fill_count - 1'b1;
              end
            end
          end
        end
      end
      S_SCAN: begin
        raddr = ptr_inc(scan_ptr);
        if (rdata.key > new_entry.key) begin
          ins_ptr_next = scan_ptr;
          state_next   = S_SHRD;
        end else if (cnt + 1'b1 == fill_count) begin
          // no larger key found: append at the tail
          we              = 1'b1;
          waddr           = tail;
          wdata           = new_entry;
          tail_next       = ptr_inc(tail);
          fill_count_next = fill_count + 1'b1;
          out_load        = 1'b1;
          out_status_next = ST_DONE;
          out_entry_next  = '0;
          out_fill_next   = fill_count + 1'b1;
          state_next      = S_SETTLE;
        end else begin
          cnt_next      = cnt + 1'b1;
          scan_ptr_next = ptr_inc(scan_ptr);
        end
      end
      S_SHRD: begin
        raddr         = ptr_dec(tail);
        scan_ptr_next = ptr_dec(tail);
        dst_next      = tail;
        state_next    = S_SHIFT;
      end
      S_SHIFT: begin
        // move entry at scan_ptr (in rdata) up one slot, prefetch the one below
        we    = 1'b1;
        waddr = dst;
        wdata = rdata;
        raddr = ptr_dec(scan_ptr);
        if (scan_ptr == ins_ptr) begin
          state_next = S_INS;
        end else begin
          scan_ptr_next = ptr_dec(scan_ptr);
          dst_next      = scan_ptr;
        end
      end
      S_INS: begin
        we              = 1'b1;
        waddr           = ins_ptr;
        wdata           = new_entry;
        tail_next       = ptr_inc(tail);
        fill_count_next = fill_count + 1'b1;
        out_load        = 1'b1;
        out_status_next = ST_DONE;
        out_entry_next  = '0;
        out_fill_next   = fill_count + 1'b1;
        state_next      = S_SETTLE;
      end
      S_SETTLE: begin
        // refresh the head read after the last write or head move
        raddr      = head;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_xfer) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      tail       <= tail_next;
      fill_count <= fill_count_next;
      out_valid  <= out_valid_next;
    end
    scan_ptr   <= scan_ptr_next;
    dst        <= dst_next;
    cnt        <= cnt_next;
    ins_ptr    <= ins_ptr_next;
    new_entry  <= new_entry_next;
    out_status <= out_status_next;
    out_entry  <= out_entry_next;
    out_fill   <= out_fill_next;
  end

  assign fill_ext = {4'b0000, out_fill};
  assign status   = out_status;
  assign head_id  = out_entry.task_id;
  assign head_key = out_entry.key;
  assign fill     = fill_ext[3:0];

endmodule

// ----- rtl/srq_checker.sv -----
// Port-level checker for the sorted ready queue core, with its bind.
// Depends on srq_pkg and sorted_ready_queue_core.
module srq_checker
  import srq_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  head_id,
  input logic [15:0] head_key,
  input logic [3:0]  fill
);

  // an input transfer only happens when the result slot is free or draining
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input transfer while result slot is blocked");

  // one item at a time: no back-to-back input transfers
  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an input transfer");

  // rejected pushes and empty pops or peeks report no head entry
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL || status == ST_EMPTY)) |->
      (head_id == 8'd0 && head_key == 16'd0))
    else $error("head fields not zero on full or empty status");

  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |-> (fill == 4'd0))
    else $error("empty status with nonzero fill");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(head_id) && $stable(fill)))
    else $error("stalled result changed");

endmodule

bind sorted_ready_queue_core srq_checker u_srq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status),
  .head_id   (head_id),
  .head_key  (head_key),
  .fill      (fill)
);

// ----- dv/tb_sorted_ready_queue_core.sv -----
// Testbench for sorted_ready_queue_core: directed and random push/pop/peek traffic,
// checked against an in-bench model of the sorted queue.
// Depends on srq_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_sorted_ready_queue_core
  import srq_pkg::*;
();

  localparam int SLOTS       = 16;
  localparam int ITEM_TARGET = 1550;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 50;

  typedef struct {
    status_t     status;
    logic [7:0]  head_id;
    logic [15:0] head_key;
    logic [3:0]  fill;
  } queue_result_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  op;
  logic [7:0]  task_id;
  logic [15:0] task_key;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic [7:0]  head_id;
  logic [15:0] head_key;
  logic [3:0]  fill;

  // Model of the queue contents, head at index 0
  entry_t        model_slot [SLOTS];
  int            model_fill;
  queue_result_t pending_results [$];

  int mismatch_count = 0;
  int items_sent;
  int stall_cycles = 0;
  bit gap_free;

  sorted_ready_queue_core #(
    .ENTRY_SLOTS(SLOTS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .op       (op),
    .task_id  (task_id),
    .task_key (task_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .head_id  (head_id),
    .head_key (head_key),
    .fill     (fill)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic queue_result_t predict_queue_op(op_t kind, logic [7:0] id,
                                                     logic [15:0] key);
    queue_result_t r;
    int pos;
    r = '{status: ST_DONE, head_id: 8'h00, head_key: 16'h0000, fill: 4'h0};
    case (kind)
      OP_PUSH, OP_PUSH_SORTED: begin
        if (model_fill >= SLOTS - 1) begin
          r.status = ST_FULL;
        end else begin
          pos = model_fill;
          if (kind == OP_PUSH_SORTED) begin
            // stop at the first entry with a strictly larger key
            pos = 0;
            while (pos < model_fill && model_slot[pos].key <= key) pos++;
          end
          for (int i = model_fill; i > pos; i--) model_slot[i] = model_slot[i - 1];
          model_slot[pos] = '{task_id: id, key: key};
          model_fill++;
        end
      end
      default: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_id  = model_slot[0].task_id;
          r.head_key = model_slot[0].key;
          if (kind == OP_POP) begin
            for (int i = 0; i + 1 < model_fill; i++) model_slot[i] = model_slot[i + 1];
            model_fill--;
          end
        end
      end
    endcase
    r.fill = model_fill[3:0];
    return r;
  endfunction

  function automatic int draw_gap();
    return gap_free ? 0 : $urandom_range(0, 13);
  endfunction

  // Extremes and narrow ranges get ties and boundary compares often
  function automatic logic [15:0] draw_key();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      1:       return 16'($urandom_range(0, 3));
      2:       return 16'h8000 + 16'($urandom_range(0, 1));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic send_request(op_t kind, logic [7:0] id, logic [15:0] key);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= kind;
    task_id  <= id;
    task_key <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_queue_op(kind, id, key));
    items_sent++;
  endtask

  task automatic test_empty_queue();
    send_request(OP_PEEK, 8'hFF, 16'hFFFF);
    send_request(OP_POP, 8'h00, 16'h0000);
  endtask

  task automatic test_insertion_order();
    // plain pushes leave the keys out of order
    send_request(OP_PUSH, 8'hFF, 16'hFFFF);
    send_request(OP_PUSH, 8'h00, 16'h0000);
    // lands at the head: the walk stops at the first larger key
    send_request(OP_PUSH_SORTED, 8'hA5, 16'h8000);
    // equal key goes behind the earlier one
    send_request(OP_PUSH_SORTED, 8'h01, 16'h8000);
    send_request(OP_PUSH_SORTED, 8'h02, 16'hFFFF);
    send_request(OP_PUSH_SORTED, 8'h03, 16'h0000);
    send_request(OP_PEEK, 8'h00, 16'h0000);
    send_request(OP_POP, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_full_queue();
    int n;
    n = 0;
    while (model_fill < SLOTS - 1) begin
      send_request(n[0] ? OP_PUSH : OP_PUSH_SORTED, 8'h10 + 8'(n),
                   n[1] ? 16'hFFFF : 16'h0000);
      n++;
    end
    send_request(OP_PUSH, 8'hFF, 16'hFFFF);
    send_request(OP_PUSH_SORTED, 8'h00, 16'h0000);
    send_request(OP_PEEK, 8'h5A, 16'h5A5A);
  endtask

  task automatic test_random_traffic();
    int len;
    op_t kind;
    while (items_sent < ITEM_TARGET) begin
      gap_free = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // fill up, running a little past full
          len = (SLOTS - 1 - model_fill) + $urandom_range(0, 2);
          repeat (len) begin
            kind = ($urandom_range(0, 3) == 0) ? OP_PUSH : OP_PUSH_SORTED;
            send_request(kind, 8'($urandom_range(0, 255)), draw_key());
          end
        end
        3, 4, 5: begin
          // drain, running a little past empty
          len = model_fill + $urandom_range(0, 2);
          repeat (len) begin
            kind = ($urandom_range(0, 4) == 0) ? OP_PEEK : OP_POP;
            send_request(kind, 8'($urandom_range(0, 255)), draw_key());
          end
        end
        default: begin
          len = $urandom_range(4, 20);
          repeat (len) begin
            kind = op_t'($urandom_range(0, 3));
            send_request(kind, 8'($urandom_range(0, 255)), draw_key());
          end
        end
      endcase
    end
    gap_free = 1'b0;
  endtask

  initial begin : drive_result_ready
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status got %0d expected %0d", status, want.status));
        if (head_id !== want.head_id)
          report_mismatch($sformatf("head_id got %02h expected %02h", head_id, want.head_id));
        if (head_key !== want.head_key)
          report_mismatch($sformatf("head_key got %04h expected %04h", head_key,
                                    want.head_key));
        if (fill !== want.fill)
          report_mismatch($sformatf("fill got %0d expected %0d", fill, want.fill));
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_PUSH;
    task_id        = 8'h00;
    task_key       = 16'h0000;
    model_fill     = 0;
    items_sent     = 0;
    gap_free       = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_insertion_order();
    test_full_queue();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/srq_pkg.sv
rtl/sorted_ready_queue_core.sv
rtl/srq_checker.sv
dv/tb_sorted_ready_queue_core.sv
